/* hw/rtl/mad_pkg.sv */
// shared constants and types for the magnetic anomaly detector
package mad_pkg;

  localparam int DEF_SAMPLE_BITS = 18;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int NUM_AXES        = 3;

  localparam int THR_W       = 18;
  localparam int ALPHA_W     = 16;
  localparam int DEV_W       = 38;
  localparam int DEV_TDATA_W = ((DEV_W + 7) / 8) * 8;
  localparam int THR_SQ_W    = 2 * THR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd1;

  localparam logic [THR_W-1:0]    THR_RESET    = 18'd8197;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd3277;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);

  // per-lane control from the pipeline sequencer
  typedef struct packed {
    logic accept;   // a sample word enters the lanes
    logic first;    // averages not loaded yet: load and report zero
    logic adv_sq;   // squaring stage takes the lane's difference
  } lane_ctrl_t;

endpackage

/* hw/rtl/mad_lane.sv */
// one axis lane: moving average, whole-count deviation and its square
module mad_lane
  import mad_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [ALPHA_W-1:0]             alpha,
  input  lane_ctrl_t                     ctrl,
  output logic [2*(SAMPLE_BITS+1)-1:0]   sq
);

  localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int MAG_W  = SAMPLE_BITS + 1;
  localparam int PROD_W = AVG_W + 1 + ALPHA_W + 1;

  logic [AVG_W-1:0]         avg;
  logic [AVG_W-1:0]         avg_next;
  logic [AVG_W-1:0]         fixed;
  logic signed [AVG_W:0]    diff;
  logic [MAG_W-1:0]         whole;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         mag_next;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    fixed    = {sample, {FRAC_BITS{1'b0}}};
    diff     = $signed({1'b0, fixed}) - $signed({1'b0, avg});
    // floor to whole counts: top bits of the signed difference
    whole    = diff[AVG_W:FRAC_BITS];
    mag_next = whole[MAG_W-1] ? (~whole + 1'b1) : whole;
    prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha}));
    // arithmetic shift by the alpha fraction width, kept to average width
    avg_next = avg + prod[ALPHA_W +: AVG_W];
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      avg <= ctrl.first ? fixed : avg_next;
      mag <= ctrl.first ? '0 : mag_next;
    end
    if (ctrl.adv_sq) begin
      sq <= {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};
    end
  end

endmodule

/* hw/rtl/mad_merge.sv */
// sums the lane squares, compares against the squared limit, output register
module mad_merge
  import mad_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [2*(SAMPLE_BITS+1)-1:0]   sq [NUM_AXES],
  input  logic [THR_SQ_W-1:0]            thr_sq,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           anomaly,
  output logic [DEV_W-1:0]               dev
);

  localparam int SQ_W  = 2 * (SAMPLE_BITS + 1);
  localparam int SUM_W = SQ_W + 2;
  localparam int EXT_W = (SUM_W > DEV_W) ? SUM_W : DEV_W;

  logic [EXT_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum = sum + EXT_W'(sq[i]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      // compare uses the full sum, the reported value is cut to its width
      anomaly <= (sum > EXT_W'(thr_sq));
      dev     <= sum[DEV_W-1:0];
    end
  end

endmodule

/* hw/rtl/magnetic_anomaly_detector.sv */
// top level: three axis lanes, pipeline control, merge and configuration
//
//  channel  | signals                         | word
//  ---------+---------------------------------+-------------------------------------
//  s_*      | s_tvalid s_tready s_tdata       | x_count, y_count, z_count
//  m_*      | m_tvalid m_tready m_tdata m_tuser | deviation_squared, anomaly flag
//  cfg_*    | cfg_valid cfg_ready cfg_index cfg_data | 0 threshold_counts, 1 smoothing_alpha
//
// one sample word per cycle unless the output stalls and the stages are full
// the per-axis average update (subtract, alpha multiply, add) is combinational into the average register
// stages: lane difference, lane square, merge sum/compare into the output register
// rst clears the pipeline valids and the average-loaded flag and reloads the config registers' reset values
// a stalled output fills the empty stages first; s_tready drops once all are full
module magnetic_anomaly_detector
  import mad_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [((NUM_AXES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // x_count, y_count, z_count
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [DEV_TDATA_W-1:0]                    m_tdata,  // deviation_squared
  output logic                                      m_tuser,  // anomaly
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]                      cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_data
);

  localparam int SQ_W = 2 * (SAMPLE_BITS + 1);

  logic [THR_SQ_W-1:0] thr_sq;
  logic [ALPHA_W-1:0]  alpha;
  logic                avg_valid;
  logic                v1;
  logic                v2;
  logic                ready1;
  logic                ready2;
  logic                ready3;
  logic                accept;
  lane_ctrl_t          lane_ctrl;
  logic [SQ_W-1:0]     sq [NUM_AXES];
  logic [DEV_W-1:0]    dev;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq <= THR_SQ_RESET;
      alpha  <= ALPHA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: thr_sq <= THR_SQ_W'(cfg_data[THR_W-1:0]) *
                                 THR_SQ_W'(cfg_data[THR_W-1:0]);
        REG_ALPHA:     alpha  <= cfg_data[ALPHA_W-1:0];
        default:       ;
      endcase
    end
  end

  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && s_tready;

  assign lane_ctrl.accept = accept;
  assign lane_ctrl.first  = !avg_valid;
  assign lane_ctrl.adv_sq = ready2 && v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      avg_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= s_tvalid;
      if (ready2) v2 <= v1;
      if (accept) avg_valid <= 1'b1;
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    mad_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .sample(s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .alpha (alpha),
      .ctrl  (lane_ctrl),
      .sq    (sq[i])
    );
  end

  mad_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .sq       (sq),
    .thr_sq   (thr_sq),
    .in_valid (v2),
    .in_ready (ready3),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .anomaly  (m_tuser),
    .dev      (dev)
  );

  assign m_tdata = {{(DEV_TDATA_W-DEV_W){1'b0}}, dev};

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && m_tvalid && !m_tready))
    else $error("input stalled with a free pipeline stage");

  a_diff_moves_on: assert property (@(posedge clk) disable iff (rst)
    (v1 && ready2) |=> v2)
    else $error("difference stage word lost on advance");

  a_sq_held: assert property (@(posedge clk) disable iff (rst)
    (v2 && !ready2) |=> (v2 && $stable(sq[0]) && $stable(sq[1]) && $stable(sq[2])))
    else $error("square stage changed while stalled");

  a_first_loads: assert property (@(posedge clk) disable iff (rst)
    (accept && !avg_valid) |=> avg_valid)
    else $error("averages not marked loaded after first word");
`endif

endmodule

/* test/tb.sv */
// testbench for the magnetic anomaly detector: directed corners and random sample streams
module tb;
  import mad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SMP_W        = DEF_SAMPLE_BITS;
  localparam int AVG_W        = DEF_SAMPLE_BITS + DEF_FRAC_BITS;
  localparam int S_TDATA_W    = ((NUM_AXES * DEF_SAMPLE_BITS + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 6;
  localparam int CHUNK_ITEMS  = 95;

  // indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [SMP_W-1:0] SMP_MAX = '1;

  typedef struct packed {
    logic             anomaly;
    logic [DEV_W-1:0] deviation_squared;
  } detection_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;   // x_count, y_count, z_count
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [DEV_TDATA_W-1:0] m_tdata;        // deviation_squared
  logic                   m_tuser;        // anomaly
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int send_idle_pct = 24;
  int recv_idle_pct = 59;
  int mismatches = 0;

  // predictor state
  logic [AVG_W-1:0]   avg_model [NUM_AXES];
  logic               avg_loaded = 1'b0;
  logic [THR_W-1:0]   thr_model = THR_RESET;
  logic [ALPHA_W-1:0] alpha_model = ALPHA_RESET;

  detection_t expected_detections [$];

  magnetic_anomaly_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // squared whole-count deviation of one axis, then move its average
  function automatic longint axis_deviation_sq(input int axis, input logic [SMP_W-1:0] sample);
    longint fixed_val, diff, whole, step;
    fixed_val = longint'(sample) << DEF_FRAC_BITS;
    diff = fixed_val - longint'(avg_model[axis]);
    whole = diff >>> DEF_FRAC_BITS;
    if (whole < 0) whole = -whole;
    // floor of alpha * diff / 2^16
    step = (longint'(alpha_model) * diff) >>> ALPHA_W;
    avg_model[axis] = AVG_W'(longint'(avg_model[axis]) + step);
    return whole * whole;
  endfunction

  function automatic detection_t predict_detection(input logic [SMP_W-1:0] x,
                                                   input logic [SMP_W-1:0] y,
                                                   input logic [SMP_W-1:0] z);
    detection_t r;
    longint total, limit;
    r = '0;
    if (!avg_loaded) begin
      avg_model[0] = AVG_W'(longint'(x) << DEF_FRAC_BITS);
      avg_model[1] = AVG_W'(longint'(y) << DEF_FRAC_BITS);
      avg_model[2] = AVG_W'(longint'(z) << DEF_FRAC_BITS);
      avg_loaded = 1'b1;
      return r;
    end
    total = axis_deviation_sq(0, x) + axis_deviation_sq(1, y) + axis_deviation_sq(2, z);
    limit = longint'(thr_model) * longint'(thr_model);
    r.anomaly = (total > limit);
    r.deviation_squared = DEV_W'(total);
    return r;
  endfunction

  // handshakes are sampled at the falling edge, where everything has settled
  always @(negedge clk) begin
    detection_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_detections.size() == 0) begin
        $error("unexpected result word: deviation_squared %0d anomaly %0d",
               m_tdata[DEV_W-1:0], m_tuser);
        mismatches++;
      end else begin
        want = expected_detections.pop_front();
        if (m_tuser !== want.anomaly) begin
          $error("anomaly expected %0d actual %0d", want.anomaly, m_tuser);
          mismatches++;
        end
        if (m_tdata[DEV_W-1:0] !== want.deviation_squared) begin
          $error("deviation_squared expected %0d actual %0d",
                 want.deviation_squared, m_tdata[DEV_W-1:0]);
          mismatches++;
        end
      end
    end
  end

  task automatic send_sample(input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] y,
                             input logic [SMP_W-1:0] z);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({z, y, x});
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    expected_detections.push_back(predict_detection(x, y, z));
  endtask

  // leaves cfg_valid high so back-to-back writes never toggle it
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    if (idx == REG_THRESHOLD) thr_model = value[THR_W-1:0];
    else if (idx == REG_ALPHA) alpha_model = value[ALPHA_W-1:0];
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_detections.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [ALPHA_W-1:0] alpha);
    wait_drained();
    set_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    // bits above the alpha field carry junk, the block must drop them
    set_reg(REG_ALPHA, {2'($urandom), alpha});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_first_sample();
    // loads the averages and must report zero
    send_sample(SMP_MAX, SMP_MAX, SMP_MAX);
    send_sample('0, '0, '0);
    send_sample(SMP_MAX, '0, SMP_MAX);
  endtask

  task automatic test_field_extremes();
    send_sample(18'h2AAAA, 18'h15555, 18'h2AAAA);
    send_sample(18'h15555, 18'h2AAAA, 18'h15555);
    send_sample(18'h15555, 18'h2AAAA, 18'h15555);
    send_sample(18'h15556, 18'h2AAA9, 18'h15555);
    send_sample('0, SMP_MAX, 18'h20000);
    send_sample(SMP_MAX, '0, 18'h1FFFF);
  endtask

  task automatic test_threshold_zero();
    configure('0, ALPHA_RESET);
    send_sample(18'h12345, 18'h12345, 18'h12345);
    send_sample(18'h12345, 18'h12345, 18'h12345);
    send_sample(18'h12346, 18'h12345, 18'h12344);
  endtask

  task automatic test_alpha_zero();
    // averages frozen after this point
    configure(THR_RESET, '0);
    send_sample('0, '0, '0);
    send_sample(SMP_MAX, 18'h00100, 18'h3FF00);
    send_sample('0, '0, '0);
  endtask

  task automatic test_alpha_max();
    configure(THR_RESET, '1);
    send_sample(SMP_MAX, SMP_MAX, SMP_MAX);
    send_sample(SMP_MAX, SMP_MAX, SMP_MAX);
    send_sample('0, '0, '0);
  endtask

  task automatic test_threshold_max();
    configure('1, '1);
    send_sample(SMP_MAX, '0, SMP_MAX);
    send_sample('0, SMP_MAX, '0);
    send_sample(SMP_MAX, '0, '0);
  endtask

  task automatic test_unknown_index();
    wait_drained();
    set_reg(REG_SPARE_2, '1);
    set_reg(REG_SPARE_3, '0);
    cfg_valid <= 1'b0;
    send_sample(18'h00001, 18'h3FFFE, 18'h20000);
    send_sample(18'h3FFFE, 18'h00001, 18'h1FFFF);
  endtask

  function automatic logic [SMP_W-1:0] near_point(input logic [SMP_W-1:0] centre, input int span);
    int v;
    v = int'(centre) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > int'(SMP_MAX)) v = int'(SMP_MAX);
    return SMP_W'(v);
  endfunction

  task automatic test_random_traffic(input int items, input int sender_pct, input int receiver_pct);
    int span, kind;
    logic [THR_W-1:0] thr;
    logic [ALPHA_W-1:0] alpha;
    logic [SMP_W-1:0] centre [NUM_AXES];
    logic [SMP_W-1:0] smp [NUM_AXES];
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int n = 0; n < items; n++) begin
      if (n % CHUNK_ITEMS == 0) begin
        case ($urandom_range(3))
          0: span = 4;
          1: span = 200;
          2: span = 6000;
          default: span = 100000;
        endcase
        case ($urandom_range(5))
          0: thr = '0;
          1: thr = '1;
          2: thr = THR_RESET;
          default: thr = THR_W'($urandom_range(2 * span));
        endcase
        case ($urandom_range(3))
          0: alpha = '0;
          1: alpha = '1;
          default: alpha = ALPHA_W'($urandom);
        endcase
        for (int a = 0; a < NUM_AXES; a++) centre[a] = SMP_W'($urandom);
        configure(thr, alpha);
      end
      // field drifts to a new level now and then
      if ($urandom_range(99) < 4) begin
        for (int a = 0; a < NUM_AXES; a++) centre[a] = SMP_W'($urandom);
      end
      kind = $urandom_range(99);
      for (int a = 0; a < NUM_AXES; a++) begin
        if (kind < 70) smp[a] = near_point(centre[a], span);
        else if (kind < 90) smp[a] = SMP_W'($urandom);
        else smp[a] = $urandom_range(1) ? SMP_MAX : '0;
      end
      send_sample(smp[0], smp[1], smp[2]);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_first_sample();
    test_field_extremes();
    test_threshold_zero();
    test_alpha_zero();
    test_alpha_max();
    test_threshold_max();
    test_unknown_index();
    test_random_traffic(380, 24, 59);
    test_random_traffic(380, 59, 24);
    test_random_traffic(380, 0, 0);
    wait_drained();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
